// ===== hw/rtl/vn_pkg.sv =====
// vn_pkg: shared constants, types and helpers for the vector normalizer
`default_nettype none
package vn_pkg;
  localparam int unsigned CompW  = 32;
  localparam int unsigned SumW   = 65;
  localparam int unsigned MagW   = 33;
  localparam int unsigned RootW  = 32;
  localparam int unsigned QuoW   = 31;
  localparam int unsigned NumW   = 62;
  localparam int unsigned UnitW  = 32;
  localparam logic [QuoW-1:0] UnitOne = QuoW'(1) << 30;

  typedef struct packed {
    logic signed [CompW-1:0] comp_a;
    logic signed [CompW-1:0] comp_b;
    logic signed [CompW-1:0] comp_c;
    logic signed [CompW-1:0] comp_d;
  } vec_in_t;

  typedef struct packed {
    logic [MagW-1:0]         magnitude;
    logic signed [UnitW-1:0] unit_a;
    logic signed [UnitW-1:0] unit_b;
    logic signed [UnitW-1:0] unit_c;
    logic signed [UnitW-1:0] unit_d;
    logic                    zero_length;
  } vec_out_t;

  // magnitude of a 32-bit two's complement value, 32 bits unsigned
  function automatic logic [CompW-1:0] abs32(input logic [CompW-1:0] v);
    abs32 = v[CompW-1] ? (~v + CompW'(1)) : v;
  endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/vn_if.sv =====
// vn_if: valid/ready channels for input and result words
`default_nettype none
interface vn_in_if import vn_pkg::*; ();
  logic    valid;
  logic    ready;
  vec_in_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface vn_out_if import vn_pkg::*; ();
  logic     valid;
  logic     ready;
  vec_out_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/vector4_normalize.sv =====
// vector4_normalize: pipelined fixed-point normalizer of four-component vectors
//
//  channel | dir | word
//  in_     | in  | comp_a..comp_d, signed Q16.16
//  out_    | out | magnitude unsigned Q17.16, unit_a..unit_d Q2.30, zero_length
//
//  One word accepted per cycle while the pipe advances; the result word passes through
//  1 input register, 2 square/sum stages, 32 square-root cells, 62 division cells
//  and 1 output register; saturation is combinational before the output register.
//  The whole pipe advances only when the output register is free or being taken.
//  Reset clears the valid bits only.
`default_nettype none
module vector4_normalize import vn_pkg::*; (
  input wire logic clk,
  input wire logic rst_n,
  vn_in_if.sink    in_ch,
  vn_out_if.source out_ch
);
  localparam int unsigned NSQ  = RootW;
  localparam int unsigned NDV  = NumW;
  localparam int unsigned NSTG = 3 + NSQ + NDV;

  logic adv;
  logic [NSTG-1:0] vld_r;
  logic out_vld_r;
  vec_out_t out_r;

  assign adv = !out_vld_r || out_ch.ready;
  assign in_ch.ready = adv;

  // stage 0: input register
  vec_in_t in_r;
  always_ff @(posedge clk) if (adv) in_r <= in_ch.data;

  // stage 1: squares
  logic [4*CompW-1:0] c1_r;
  logic [63:0] sq_r [4];
  always_ff @(posedge clk) begin
    if (adv) begin
      c1_r <= in_r;
      sq_r[0] <= 64'(abs32(in_r.comp_a)) * 64'(abs32(in_r.comp_a));
      sq_r[1] <= 64'(abs32(in_r.comp_b)) * 64'(abs32(in_r.comp_b));
      sq_r[2] <= 64'(abs32(in_r.comp_c)) * 64'(abs32(in_r.comp_c));
      sq_r[3] <= 64'(abs32(in_r.comp_d)) * 64'(abs32(in_r.comp_d));
    end
  end

  // stage 2: sum; only a sum of exactly 2^64 reaches bit 64
  logic [4*CompW-1:0] c2_r;
  logic [SumW-1:0] sum_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      c2_r  <= c1_r;
      sum_r <= SumW'(sq_r[0]) + SumW'(sq_r[1]) + SumW'(sq_r[2]) + SumW'(sq_r[3]);
    end
  end

  // square-root chain
  logic [63:0]        srem [NSQ+1];
  logic [RootW-1:0]   sroot[NSQ+1];
  logic [4*CompW-1:0] scomp[NSQ+1];
  logic               sbig [NSQ+1];
  assign srem[0]  = sum_r[63:0];
  assign sroot[0] = '0;
  assign scomp[0] = c2_r;
  assign sbig[0]  = sum_r[64];

  for (genvar g = 0; g < NSQ; g++) begin : g_sq
    vn_sqrt_cell #(.BIT(NSQ-1-g)) u_cell (
      .clk(clk), .en(adv),
      .rem_i(srem[g]), .root_i(sroot[g]), .comp_i(scomp[g]), .big_i(sbig[g]),
      .rem_o(srem[g+1]), .root_o(sroot[g+1]), .comp_o(scomp[g+1]), .big_o(sbig[g+1])
    );
  end

  logic [MagW-1:0] mag;
  assign mag = sbig[NSQ] ? (MagW'(1) << RootW) : {1'b0, sroot[NSQ]};

  // division chain; lane 3 carries comp_a, lane 0 carries comp_d
  logic [4*(MagW+1)-1:0] drem[NDV+1];
  logic [4*NumW-1:0]     dnum[NDV+1];
  logic [4*QuoW-1:0]     dquo[NDV+1];
  logic [3:0]            dsgn[NDV+1];
  logic [MagW-1:0]       ddiv[NDV+1];
  logic [4*NumW-1:0]     num0;
  logic [3:0]            sgn0;

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      num0[l*NumW +: NumW] = {abs32(scomp[NSQ][l*CompW +: CompW]), 30'd0};
      sgn0[l] = scomp[NSQ][l*CompW + CompW-1];
    end
  end
  assign dnum[0] = num0;
  assign dsgn[0] = sgn0;
  assign drem[0] = '0;
  assign dquo[0] = '0;
  assign ddiv[0] = mag;

  for (genvar g = 0; g < NDV; g++) begin : g_dv
    vn_div_cell #(.BIT(NDV-1-g)) u_cell (
      .clk(clk), .en(adv),
      .rem_i(drem[g]), .num_i(dnum[g]), .quo_i(dquo[g]), .sign_i(dsgn[g]), .div_i(ddiv[g]),
      .rem_o(drem[g+1]), .num_o(dnum[g+1]), .quo_o(dquo[g+1]), .sign_o(dsgn[g+1]),
      .div_o(ddiv[g+1])
    );
  end

  // final stage: saturate, sign, zero case
  vec_out_t res;
  always_comb begin
    logic [QuoW-1:0] q;
    logic [UnitW-1:0] u [4];
    logic z;
    z = (ddiv[NDV] == '0);
    for (int l = 0; l < 4; l++) begin
      q = dquo[NDV][l*QuoW +: QuoW];
      if (q > UnitOne) q = UnitOne;
      u[l] = dsgn[NDV][l] ? (~UnitW'(q) + UnitW'(1)) : UnitW'(q);
      if (z) u[l] = '0;
    end
    res.magnitude   = ddiv[NDV];
    res.unit_a      = u[3];
    res.unit_b      = u[2];
    res.unit_c      = u[1];
    res.unit_d      = u[0];
    res.zero_length = z;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      vld_r     <= {vld_r[NSTG-2:0], in_ch.valid};
      out_vld_r <= vld_r[NSTG-1];
    end
  end

  always_ff @(posedge clk) if (adv) out_r <= res;

  assign out_ch.valid = out_vld_r;
  assign out_ch.data  = out_r;

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
    else $error("result dropped during stall");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_ch.valid |-> in_ch.ready)
    else $error("pipe stalled with empty output");
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.data.zero_length |-> out_ch.data.magnitude == '0
      && out_ch.data.unit_a == '0 && out_ch.data.unit_d == '0)
    else $error("zero vector gave nonzero unit");
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> vld_r[0] == $past(in_ch.valid))
    else $error("input valid lost");
endmodule
`default_nettype wire

// ===== hw/rtl/vn_sqrt_cell.sv =====
// vn_sqrt_cell: one restoring square-root step, registered, carries operands along
`default_nettype none
module vn_sqrt_cell import vn_pkg::*; #(
  parameter int unsigned BIT = 31
) (
  input  wire logic                clk,
  input  wire logic                en,
  input  wire logic [63:0]         rem_i,
  input  wire logic [RootW-1:0]    root_i,
  input  wire logic [4*CompW-1:0]  comp_i,
  input  wire logic                big_i,
  output logic      [63:0]         rem_o,
  output logic      [RootW-1:0]    root_o,
  output logic      [4*CompW-1:0]  comp_o,
  output logic                     big_o
);
  // non-restoring-free form: trial = (2*root + 2^bit) << bit, compared with remainder
  logic [65:0] trial;
  logic        take;
  logic [63:0] rem_r;
  logic [RootW-1:0] root_r;
  logic [4*CompW-1:0] comp_r;
  logic big_r;

  assign trial = ({33'd0, root_i, 1'b0} + (66'd1 << BIT)) << BIT;
  assign take  = trial <= {2'b00, rem_i};

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= take ? rem_i - trial[63:0] : rem_i;
      root_r <= take ? (root_i | (RootW'(1) << BIT)) : root_i;
      comp_r <= comp_i;
      big_r  <= big_i;
    end
  end

  assign rem_o  = rem_r;
  assign root_o = root_r;
  assign comp_o = comp_r;
  assign big_o  = big_r;
endmodule
`default_nettype wire

// ===== hw/rtl/vn_div_cell.sv =====
// vn_div_cell: one restoring division step for four lanes sharing a divisor
`default_nettype none
module vn_div_cell import vn_pkg::*; #(
  parameter int unsigned BIT = 61
) (
  input  wire logic                   clk,
  input  wire logic                   en,
  input  wire logic [4*(MagW+1)-1:0]  rem_i,
  input  wire logic [4*NumW-1:0]      num_i,
  input  wire logic [4*QuoW-1:0]      quo_i,
  input  wire logic [3:0]             sign_i,
  input  wire logic [MagW-1:0]        div_i,
  output logic      [4*(MagW+1)-1:0]  rem_o,
  output logic      [4*NumW-1:0]      num_o,
  output logic      [4*QuoW-1:0]      quo_o,
  output logic      [3:0]             sign_o,
  output logic      [MagW-1:0]        div_o
);
  logic [4*(MagW+1)-1:0] rem_r;
  logic [4*NumW-1:0]     num_r;
  logic [4*QuoW-1:0]     quo_r;
  logic [3:0]            sign_r;
  logic [MagW-1:0]       div_r;
  logic [4*(MagW+1)-1:0] rem_nxt;
  logic [4*QuoW-1:0]     quo_nxt;

  always_comb begin
    logic [MagW+1:0] sh;
    logic [QuoW:0]   q;
    rem_nxt = '0;
    quo_nxt = '0;
    for (int l = 0; l < 4; l++) begin
      sh = {rem_i[l*(MagW+1) +: MagW+1], num_i[l*NumW+BIT]};
      q  = {quo_i[l*QuoW +: QuoW], 1'b0};
      if (sh >= {2'b00, div_i}) begin
        sh = sh - {2'b00, div_i};
        q[0] = 1'b1;
      end
      rem_nxt[l*(MagW+1) +: MagW+1] = sh[MagW:0];
      // quotient cannot exceed 2^31, saturate once the 2^30 limit is passed
      quo_nxt[l*QuoW +: QuoW] = (q > {1'b0, UnitOne}) ? (UnitOne + QuoW'(1)) : q[QuoW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      num_r  <= num_i;
      quo_r  <= quo_nxt;
      sign_r <= sign_i;
      div_r  <= div_i;
    end
  end

  assign rem_o  = rem_r;
  assign num_o  = num_r;
  assign quo_o  = quo_r;
  assign sign_o = sign_r;
  assign div_o  = div_r;
endmodule
`default_nettype wire

// ===== dv/vector4_normalize_chk.sv =====
// Checker: watches both channels, predicts normalised vectors and compares them
`timescale 1ns / 100ps
module vector4_normalize_chk import vn_pkg::*; (
  input wire logic clk,
  input wire logic rst_n,
  vn_in_if.sink    in_mon,
  vn_out_if.sink   out_mon,
  output int       fail_count,
  output int       pending
);
  vec_out_t expected_q[$];

  function automatic logic [31:0] mag_of(input logic [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  function automatic logic [31:0] floor_root(input logic [63:0] s);
    logic [31:0] r;
    logic [31:0] c;
    r = '0;
    for (int b = 31; b >= 0; b--) begin
      c = r | (32'd1 << b);
      if ({32'd0, c} * {32'd0, c} <= s) r = c;
    end
    return r;
  endfunction

  function automatic logic [31:0] unit_of(input logic [31:0] v, input logic [32:0] m);
    logic [63:0] q;
    q = {mag_of(v), 30'd0} / {31'd0, m};
    if (q > 64'd1073741824) q = 64'd1073741824;
    if (v[31]) q = ~q + 64'd1;
    return q[31:0];
  endfunction

  function automatic vec_out_t normalise(input vec_in_t w);
    logic [64:0] sum;
    logic [31:0] a;
    logic [32:0] m;
    vec_out_t r;
    sum = '0;
    for (int i = 0; i < 4; i++) begin
      a = mag_of(w[127 - 32*i -: 32]);
      sum += {33'd0, a} * {33'd0, a};
    end
    m = sum[64] ? 33'h1_0000_0000 : {1'b0, floor_root(sum[63:0])};
    r.magnitude = m;
    r.zero_length = (m == '0);
    if (r.zero_length) begin
      r.unit_a = '0; r.unit_b = '0; r.unit_c = '0; r.unit_d = '0;
    end else begin
      r.unit_a = unit_of(w.comp_a, m);
      r.unit_b = unit_of(w.comp_b, m);
      r.unit_c = unit_of(w.comp_c, m);
      r.unit_d = unit_of(w.comp_d, m);
    end
    return r;
  endfunction

  initial begin
    fail_count = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    vec_out_t e, g;
    if (rst_n) begin
      if (in_mon.valid && in_mon.ready) expected_q.push_back(normalise(in_mon.data));
      if (out_mon.valid && out_mon.ready) begin
        g = out_mon.data;
        if (expected_q.size() == 0) begin
          $error("result word with no expectation: %p", g);
          fail_count++;
        end else begin
          e = expected_q.pop_front();
          if (g.magnitude !== e.magnitude) begin
            $error("magnitude exp %h got %h", e.magnitude, g.magnitude); fail_count++;
          end
          if (g.unit_a !== e.unit_a) begin
            $error("unit_a exp %h got %h", e.unit_a, g.unit_a); fail_count++;
          end
          if (g.unit_b !== e.unit_b) begin
            $error("unit_b exp %h got %h", e.unit_b, g.unit_b); fail_count++;
          end
          if (g.unit_c !== e.unit_c) begin
            $error("unit_c exp %h got %h", e.unit_c, g.unit_c); fail_count++;
          end
          if (g.unit_d !== e.unit_d) begin
            $error("unit_d exp %h got %h", e.unit_d, g.unit_d); fail_count++;
          end
          if (g.zero_length !== e.zero_length) begin
            $error("zero_length exp %b got %b", e.zero_length, g.zero_length); fail_count++;
          end
        end
      end
      pending = expected_q.size();
    end
  end
endmodule

// ===== dv/vector4_normalize_tb.sv =====
// Testbench top: drives vectors with random gaps and stalls, gives the verdict
`timescale 1ns / 100ps
module vector4_normalize_tb import vn_pkg::*;;
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   fail_count;
  int   pending;
  int   cycles = 0;
  bit   hold_done = 1'b0;
  bit   send_done = 1'b0;

  localparam int CycleLimit = 400000;
  localparam int RandomWords = 530;

  vn_in_if  in_ch ();
  vn_out_if out_ch ();

  vector4_normalize dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source));

  vector4_normalize_chk chk (
    .clk(clk), .rst_n(rst_n), .in_mon(in_ch.sink), .out_mon(out_ch.sink),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAIL vector4_normalize");
      $finish;
    end
  end

  function automatic int gap_len();
    int p;
    p = $urandom_range(99);
    if (p < 45) return 0;
    if (p < 92) return $urandom_range(3, 1);
    return $urandom_range(60, 10);
  endfunction

  function automatic logic [31:0] rand_comp();
    case ($urandom_range(7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(3);
      3: return -$urandom_range(3);
      4: return $urandom_range(32'h0001_ffff) - 32'h0001_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_word(input vec_in_t w);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= w;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // receiver: one long hold-off first, then random stalls
  initial begin
    int g;
    out_ch.ready = 1'b0;
    wait (rst_n);
    repeat (300) @(posedge clk);
    hold_done = 1'b1;
    forever begin
      out_ch.ready <= 1'b1;
      @(posedge clk);
      if ($urandom_range(3) == 0) begin
        g = gap_len();
        if (g > 0) begin
          out_ch.ready <= 1'b0;
          repeat (g) @(posedge clk);
        end
      end
    end
  end

  initial begin
    vec_in_t w;
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: zero vector, extremes, largest sum, tiny and unit-axis vectors
    send_word('{32'h0, 32'h0, 32'h0, 32'h0});
    send_word('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
    send_word('{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff});
    send_word('{32'h8000_0000, 32'h0, 32'h0, 32'h0});
    send_word('{32'h0, 32'h7fff_ffff, 32'h0, 32'h0});
    send_word('{32'h0, 32'h0, 32'h0001_0000, 32'h0});
    send_word('{32'h0, 32'h0, 32'h0, 32'hffff_0000});
    send_word('{32'h1, 32'h0, 32'h0, 32'h0});
    send_word('{32'hffff_ffff, 32'h0, 32'h0, 32'h0});
    send_word('{32'h1, 32'h1, 32'h0, 32'h0});
    send_word('{32'h1, 32'hffff_ffff, 32'h1, 32'hffff_ffff});
    send_word('{32'h2, 32'h3, 32'h0, 32'h0});
    send_word('{32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff});
    send_word('{32'h5555_5555, 32'haaaa_aaaa, 32'h0, 32'h1});
    send_word('{32'h0003_0000, 32'h0004_0000, 32'h0, 32'h0});
    send_word('{32'h0, 32'h0, 32'hfffd_0000, 32'hfffc_0000});
    // random words: back-to-back during the long hold-off to fill the pipe, then with random gaps
    for (int i = 0; i < RandomWords; i++) begin
      w.comp_a = rand_comp();
      w.comp_b = rand_comp();
      w.comp_c = rand_comp();
      w.comp_d = rand_comp();
      if (!hold_done) begin
        in_ch.valid <= 1'b1;
        in_ch.data  <= w;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
      end else begin
        send_word(w);
      end
    end
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (150) @(posedge clk);
    if (fail_count == 0 && pending == 0) $display("PASS vector4_normalize");
    else $display("FAIL vector4_normalize");
    $finish;
  end
endmodule
